[rtl/sfms_pkg.sv]
// Shared types, constants and coefficient tables of the stereo FIR block.
`default_nettype none

package sfms_pkg;

    localparam int COEF_W    = 18;   // signed Q1.17
    localparam int COEF_FRAC = 17;
    localparam int ROM_IDX_W = 6;    // 6-bit coefficient index; tables hold 29 (low) and 25 (high) entries

    typedef enum logic [1:0] {
        MODE_BYPASS = 2'd0,
        MODE_LOW    = 2'd1,
        MODE_HIGH   = 2'd2,
        MODE_SPARE  = 2'd3   // behaves as bypass
    } mode_t;

    typedef struct packed {
        logic                 capture;     // input beat taken this cycle
        logic                 rotate;      // rotate active lines, form products
        logic                 accumulate;  // add registered products
        logic                 load_out;    // move result into output register
        logic [ROM_IDX_W-1:0] coef_idx;
    } sfms_cmd_t;

    typedef struct packed {
        mode_t mode;
    } sfms_stat_t;

    function automatic logic signed [COEF_W-1:0] lp_coef(input logic [ROM_IDX_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        unique case (idx)
            6'd0:    c = -18'sd1147;
            6'd1:    c = -18'sd1773;
            6'd2:    c = -18'sd2762;
            6'd3:    c = -18'sd3698;
            6'd4:    c = -18'sd4310;
            6'd5:    c = -18'sd4302;
            6'd6:    c = -18'sd3410;
            6'd7:    c = -18'sd1485;
            6'd8:    c =  18'sd1465;
            6'd9:    c =  18'sd5233;
            6'd10:   c =  18'sd9431;
            6'd11:   c =  18'sd13542;
            6'd12:   c =  18'sd17003;
            6'd13:   c =  18'sd19314;
            6'd14:   c =  18'sd20125;
            6'd15:   c =  18'sd19314;
            6'd16:   c =  18'sd17003;
            6'd17:   c =  18'sd13542;
            6'd18:   c =  18'sd9431;
            6'd19:   c =  18'sd5233;
            6'd20:   c =  18'sd1465;
            6'd21:   c = -18'sd1485;
            6'd22:   c = -18'sd3410;
            6'd23:   c = -18'sd4302;
            6'd24:   c = -18'sd4310;
            6'd25:   c = -18'sd3698;
            6'd26:   c = -18'sd2762;
            6'd27:   c = -18'sd1773;
            6'd28:   c = -18'sd1147;
            default: c =  18'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] hp_coef(input logic [ROM_IDX_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        unique case (idx)
            6'd0:    c =  18'sd7794;
            6'd1:    c = -18'sd10835;
            6'd2:    c = -18'sd4243;
            6'd3:    c =  18'sd284;
            6'd4:    c =  18'sd3756;
            6'd5:    c =  18'sd5907;
            6'd6:    c =  18'sd5813;
            6'd7:    c =  18'sd2643;
            6'd8:    c = -18'sd3631;
            6'd9:    c = -18'sd11968;
            6'd10:   c = -18'sd20442;
            6'd11:   c = -18'sd26726;
            6'd12:   c =  18'sd102004;
            6'd13:   c = -18'sd26726;
            6'd14:   c = -18'sd20442;
            6'd15:   c = -18'sd11968;
            6'd16:   c = -18'sd3631;
            6'd17:   c =  18'sd2643;
            6'd18:   c =  18'sd5813;
            6'd19:   c =  18'sd5907;
            6'd20:   c =  18'sd3756;
            6'd21:   c =  18'sd284;
            6'd22:   c = -18'sd4243;
            6'd23:   c = -18'sd10835;
            6'd24:   c =  18'sd7794;
            default: c =  18'sd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/sfms_line.sv]
// Delay line of one channel: shifts in a sample, rotates for the MAC pass.
`default_nettype none

module sfms_line #(
    parameter int TAPS        = 29,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          clear,
    input  wire logic                          shift,
    input  wire logic                          rotate,
    input  wire logic signed [SAMPLE_BITS-1:0] din,
    output logic signed [SAMPLE_BITS-1:0]      tap
);

    logic signed [SAMPLE_BITS-1:0] line_reg [TAPS];

    // A full rotation of TAPS steps leaves the line as it was; the oldest
    // entry sits at the read tap first and the others follow it, newest last.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                line_reg[k] <= '0;
            end
        end
        else if (clear)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                line_reg[k] <= '0;
            end
        end
        else if (shift)
        begin
            line_reg[0] <= din;
            for (int k = 1; k < TAPS; k++)
            begin
                line_reg[k] <= line_reg[k-1];
            end
        end
        else if (rotate)
        begin
            line_reg[0] <= line_reg[TAPS-1];
            for (int k = 1; k < TAPS; k++)
            begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    assign tap = line_reg[TAPS-1];

endmodule

`default_nettype wire

[rtl/sfms_datapath.sv]
// Datapath: mode register, four delay lines, two MACs, truncation, saturation and output registers.
`default_nettype none

module sfms_datapath #(
    parameter int LOW_TAPS    = 29,
    parameter int HIGH_TAPS   = 25,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr,
    input  wire logic [1:0]                    cfg_data,
    input  wire logic signed [SAMPLE_BITS-1:0] left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] right_sample,
    input  wire sfms_pkg::sfms_cmd_t           cmd,
    output sfms_pkg::sfms_stat_t               stat,
    output logic signed [SAMPLE_BITS-1:0]      left_out,
    output logic signed [SAMPLE_BITS-1:0]      right_out
);
    import sfms_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + COEF_W;
    localparam int ACC_W  = PROD_W + ROM_IDX_W;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((64'sd1 <<< COEF_FRAC) - 64'sd1);

    mode_t mode_reg;
    logic  clear_lines;
    logic  low_act;
    logic  high_act;

    logic signed [SAMPLE_BITS-1:0] low_l_tap, low_r_tap, high_l_tap, high_r_tap;
    logic signed [SAMPLE_BITS-1:0] tap_l, tap_r;
    logic signed [COEF_W-1:0]      coef;

    logic signed [SAMPLE_BITS-1:0] in_l_reg, in_r_reg;
    logic signed [PROD_W-1:0]      prod_l_reg, prod_r_reg;
    logic signed [ACC_W-1:0]       acc_l_reg, acc_r_reg;
    logic signed [ACC_W-1:0]       quo_l, quo_r;
    logic signed [SAMPLE_BITS-1:0] sat_l, sat_r;
    logic signed [SAMPLE_BITS-1:0] left_out_reg, right_out_reg;

    assign clear_lines = cfg_wr && (mode_t'(cfg_data) != mode_reg);
    assign low_act     = (mode_reg == MODE_LOW);
    assign high_act    = (mode_reg == MODE_HIGH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BYPASS;
        end
        else if (clear_lines)
        begin
            mode_reg <= mode_t'(cfg_data);
        end
    end

    assign stat.mode = mode_reg;

    sfms_line #(.TAPS(LOW_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_low_left (
        .clk(clk), .rst_n(rst_n), .clear(clear_lines),
        .shift(cmd.capture && low_act), .rotate(cmd.rotate && low_act),
        .din(left_sample), .tap(low_l_tap)
    );

    sfms_line #(.TAPS(LOW_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_low_right (
        .clk(clk), .rst_n(rst_n), .clear(clear_lines),
        .shift(cmd.capture && low_act), .rotate(cmd.rotate && low_act),
        .din(right_sample), .tap(low_r_tap)
    );

    sfms_line #(.TAPS(HIGH_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_high_left (
        .clk(clk), .rst_n(rst_n), .clear(clear_lines),
        .shift(cmd.capture && high_act), .rotate(cmd.rotate && high_act),
        .din(left_sample), .tap(high_l_tap)
    );

    sfms_line #(.TAPS(HIGH_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_high_right (
        .clk(clk), .rst_n(rst_n), .clear(clear_lines),
        .shift(cmd.capture && high_act), .rotate(cmd.rotate && high_act),
        .din(right_sample), .tap(high_r_tap)
    );

    assign tap_l = low_act ? low_l_tap : high_l_tap;
    assign tap_r = low_act ? low_r_tap : high_r_tap;
    assign coef  = low_act ? lp_coef(cmd.coef_idx) : hp_coef(cmd.coef_idx);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_l_reg  <= left_sample;
            in_r_reg  <= right_sample;
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (cmd.accumulate)
        begin
            acc_l_reg <= acc_l_reg + ACC_W'(prod_l_reg);
            acc_r_reg <= acc_r_reg + ACC_W'(prod_r_reg);
        end
        if (cmd.rotate)
        begin
            prod_l_reg <= tap_l * coef;
            prod_r_reg <= tap_r * coef;
        end
    end

    // truncate toward zero: bias negative sums before the arithmetic shift
    assign quo_l = (acc_l_reg + (acc_l_reg[ACC_W-1] ? TRUNC_BIAS : ACC_W'(0))) >>> COEF_FRAC;
    assign quo_r = (acc_r_reg + (acc_r_reg[ACC_W-1] ? TRUNC_BIAS : ACC_W'(0))) >>> COEF_FRAC;

    assign sat_l = (quo_l > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                   (quo_l < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : SAMPLE_BITS'(quo_l);
    assign sat_r = (quo_r > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                   (quo_r < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : SAMPLE_BITS'(quo_r);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            left_out_reg  <= (low_act || high_act) ? sat_l : in_l_reg;
            right_out_reg <= (low_act || high_act) ? sat_r : in_r_reg;
        end
    end

    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

endmodule

`default_nettype wire

[rtl/sfms_ctrl.sv]
// Controller: sequences capture, the MAC pass over the taps and the output hand-off.
`default_nettype none

module sfms_ctrl #(
    parameter int LOW_TAPS  = 29,
    parameter int HIGH_TAPS = 25
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_tvalid,
    output logic                      in_tready,
    output logic                      out_tvalid,
    input  wire logic                 out_tready,
    input  wire sfms_pkg::sfms_stat_t stat,
    output sfms_pkg::sfms_cmd_t       cmd
);
    import sfms_pkg::*;

    localparam int LONGEST_TAPS = (LOW_TAPS > HIGH_TAPS) ? LOW_TAPS : HIGH_TAPS;
    localparam int CNT_W        = (LONGEST_TAPS > 1) ? $clog2(LONGEST_TAPS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             acc_en_reg;
    logic             out_valid_reg;
    logic             accept;
    logic             load_out;

    assign in_tready = (state_reg == ST_IDLE);
    assign accept    = in_tvalid && in_tready;
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || out_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            acc_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_en_reg <= (state_reg == ST_MAC);
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (stat.mode)
                            MODE_LOW:
                            begin
                                cnt_reg   <= CNT_W'(LOW_TAPS - 1);
                                state_reg <= ST_MAC;
                            end
                            MODE_HIGH:
                            begin
                                cnt_reg   <= CNT_W'(HIGH_TAPS - 1);
                                state_reg <= ST_MAC;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_MAC:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_tvalid     = out_valid_reg;
    assign cmd.capture    = accept;
    assign cmd.rotate     = (state_reg == ST_MAC);
    assign cmd.accumulate = acc_en_reg;
    assign cmd.load_out   = load_out;
    assign cmd.coef_idx   = ROM_IDX_W'(cnt_reg);

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_tready))
        else $error("result register overwritten");

    // a beat in a filtering mode starts the MAC pass
    a_filter_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (stat.mode == MODE_LOW || stat.mode == MODE_HIGH)) |=> state_reg == ST_MAC)
        else $error("filter beat did not start MAC pass");

    // drain follows the last tap only
    a_drain_order: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_DRAIN) |-> $past(state_reg == ST_MAC && cnt_reg == '0))
        else $error("drain entered early");

    // every accumulate adds a product formed the cycle before
    a_acc_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accumulate |-> $past(cmd.rotate))
        else $error("accumulate without product");

endmodule

`default_nettype wire

[rtl/stereo_fir_mode_select.sv]
// Top level of the stereo FIR filter with bypass, low-pass and high-pass modes.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+--------------------------------
//  s_axis  | in        | s_axis_tvalid/s_axis_tready | left_sample, right_sample
//  m_axis  | out       | m_axis_tvalid/m_axis_tready | left_out, right_out
//  cfg     | in        | cfg_valid/cfg_ready         | cfg_data (2 bits)
//
// A beat passes capture, a MAC pass over the active taps (one MAC per channel, shared by
// both modes, one step per tap), drain and output load; bypass skips MAC and drain.
// Reset clears mode to bypass and all delay lines at once; no clearing pass.
// The output register frees the input side: a new beat is taken while a result waits.
// A stalled output holds the finished result in DONE until m_axis_tready.
// cfg is always ready; a mode change clears all four delay lines.
`default_nettype none

module stereo_fir_mode_select #(
    parameter int LOW_TAPS    = 29,
    parameter int HIGH_TAPS   = 25,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [SAMPLE_BITS-1:0] left_sample, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_sample
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [SAMPLE_BITS-1:0] left_out, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_out
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [1:0]                          cfg_data
);
    import sfms_pkg::*;

    localparam int DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    sfms_cmd_t  cmd;
    sfms_stat_t stat;

    logic signed [SAMPLE_BITS-1:0] left_sample, right_sample;
    logic signed [SAMPLE_BITS-1:0] left_out, right_out;

    assign cfg_ready    = 1'b1;
    assign left_sample  = s_axis_tdata[SAMPLE_BITS-1:0];
    assign right_sample = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign m_axis_tdata = DATA_W'({right_out, left_out});

    sfms_ctrl #(
        .LOW_TAPS (LOW_TAPS),
        .HIGH_TAPS(HIGH_TAPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .out_tvalid(m_axis_tvalid),
        .out_tready(m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sfms_datapath #(
        .LOW_TAPS   (LOW_TAPS),
        .HIGH_TAPS  (HIGH_TAPS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .left_sample (left_sample),
        .right_sample(right_sample),
        .cmd         (cmd),
        .stat        (stat),
        .left_out    (left_out),
        .right_out   (right_out)
    );

endmodule

`default_nettype wire
